// ===== rtl/hbled_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbled_pkg
// Shared types, codes and constants of the heartbeat LED blinker.
// ----------------------------------------------------------------------------
package hbled_pkg;

  localparam int SYMBOL_COUNT = 24;
  localparam int COLOR_W      = 24;
  localparam int CNT_W        = $clog2(SYMBOL_COUNT);
  localparam int NOW_W        = 32;
  localparam int FUNC_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int PULSE_W      = 4;

  // item codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERROR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_POLARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COLOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_COLOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_COLOR  = 3'd6;

  // result kinds
  localparam logic KIND_PIN    = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  // pulse lengths in 0.1 us
  localparam logic [PULSE_W-1:0] SYM_ZERO_HIGH = 4'd4;
  localparam logic [PULSE_W-1:0] SYM_ZERO_LOW  = 4'd8;
  localparam logic [PULSE_W-1:0] SYM_ONE_HIGH  = 4'd7;
  localparam logic [PULSE_W-1:0] SYM_ONE_LOW   = 4'd6;

  localparam logic [31:0] RST_INTERVAL = 32'd100;

  typedef struct packed {
    logic               start;
    logic               serial;
    logic               pin;
    logic [COLOR_W-1:0] grb;
  } job_t;

  // red, green, blue packed word to green, red, blue order
  function automatic logic [COLOR_W-1:0] grb_word(input logic [COLOR_W-1:0] rgb);
    grb_word = {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

// ===== rtl/hbled_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbled_if
// Input and result channels of the heartbeat LED blinker.
// ----------------------------------------------------------------------------
interface hbled_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_time;
  logic        error_value;

  modport source (output valid, output func, output now_time, output error_value,
                  input ready);
  modport sink   (input valid, input func, input now_time, input error_value,
                  output ready);
endinterface

interface hbled_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       pin_level;
  logic       symbol_bit;
  logic [3:0] high_time;
  logic [3:0] low_time;
  logic       last_symbol;

  modport source (output valid, output result_kind, output pin_level,
                  output symbol_bit, output high_time, output low_time,
                  output last_symbol, input ready);
  modport sink   (input valid, input result_kind, input pin_level,
                  input symbol_bit, input high_time, input low_time,
                  input last_symbol, output ready);
endinterface

// ===== rtl/hbled_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbled_core
// Register file and blinker state; decides per word whether the LED toggles
// and which pin level or color goes out.
// ----------------------------------------------------------------------------
module hbled_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_fire,
  input  logic [hbled_pkg::FUNC_W-1:0]         in_func,
  input  logic [hbled_pkg::NOW_W-1:0]          in_now,
  input  logic                                 in_err,
  input  logic                                 cfg_we,
  input  logic [hbled_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hbled_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hbled_pkg::job_t                      job
);
  import hbled_pkg::*;

  logic               serial_led_mode;
  logic               pin_polarity;
  logic [31:0]        toggle_interval;
  logic [31:0]        activity_window;
  logic [COLOR_W-1:0] idle_color;
  logic [COLOR_W-1:0] busy_color;
  logic [COLOR_W-1:0] fault_color;

  logic                  led_on;
  logic [TIME_WIDTH-1:0] last_toggle_time;
  logic [TIME_WIDTH-1:0] last_activity_time;
  logic                  error_flag;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] interval_t;
  logic [TIME_WIDTH-1:0] window_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] since_act;
  logic                  due;
  logic                  activity;
  logic                  led_next;
  logic [COLOR_W-1:0]    color;

  assign now_t      = TIME_WIDTH'(in_now);
  assign interval_t = TIME_WIDTH'(toggle_interval);
  assign window_t   = TIME_WIDTH'(activity_window);
  assign elapsed    = now_t - last_toggle_time;
  assign since_act  = now_t - last_activity_time;
  assign due        = (elapsed >= interval_t);
  assign activity   = (window_t != '0) && (since_act <= window_t);
  assign led_next   = ~led_on;

  always_comb begin
    if (!led_next) begin
      color = '0;
    end else if (error_flag) begin
      color = fault_color;
    end else if (activity) begin
      color = busy_color;
    end else begin
      color = idle_color;
    end
  end

  assign job.start  = in_fire && (in_func == FUNC_TICK) && due;
  assign job.serial = serial_led_mode;
  assign job.pin    = pin_polarity ? led_next : ~led_next;
  assign job.grb    = grb_word(color);

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_led_mode    <= 1'b0;
      pin_polarity       <= 1'b1;
      toggle_interval    <= RST_INTERVAL;
      activity_window    <= '0;
      idle_color         <= '0;
      busy_color         <= '0;
      fault_color        <= '0;
      led_on             <= 1'b0;
      last_toggle_time   <= '0;
      last_activity_time <= '0;
      error_flag         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SERIAL_MODE:  serial_led_mode <= cfg_data[0];
          CFG_PIN_POLARITY: pin_polarity    <= cfg_data[0];
          CFG_INTERVAL:     toggle_interval <= cfg_data;
          CFG_WINDOW:       activity_window <= cfg_data;
          CFG_IDLE_COLOR:   idle_color      <= cfg_data[COLOR_W-1:0];
          CFG_BUSY_COLOR:   busy_color      <= cfg_data[COLOR_W-1:0];
          CFG_FAULT_COLOR:  fault_color     <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        unique case (in_func)
          FUNC_MARK:  last_activity_time <= now_t;
          FUNC_ERROR: error_flag         <= in_err;
          FUNC_TICK: begin
            if (due) begin
              led_on           <= led_next;
              last_toggle_time <= now_t;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/hbled_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbled_ser
// Job register and serializer: one pin word, or 24 pulse symbols msb first,
// into a result register.
// ----------------------------------------------------------------------------
module hbled_ser (
  input  logic                                clk,
  input  logic                                rst,
  input  hbled_pkg::job_t                     job,
  output logic                                job_free,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                result_kind,
  output logic                                pin_level,
  output logic                                symbol_bit,
  output logic [hbled_pkg::PULSE_W-1:0]       high_time,
  output logic [hbled_pkg::PULSE_W-1:0]       low_time,
  output logic                                last_symbol
);
  import hbled_pkg::*;

  logic               busy;
  logic               serial;
  logic               pin;
  logic [COLOR_W-1:0] shreg;
  logic [CNT_W-1:0]   idx;
  logic               advance;
  logic               last_of_job;
  logic               sbit;

  assign advance     = busy && (!out_valid || out_ready);
  assign last_of_job = !serial || (idx == CNT_W'(SYMBOL_COUNT - 1));
  assign job_free    = !busy || (advance && last_of_job);
  assign sbit        = shreg[COLOR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        result_kind <= serial ? KIND_SYMBOL : KIND_PIN;
        pin_level   <= serial ? 1'b0 : pin;
        symbol_bit  <= serial ? sbit : 1'b0;
        high_time   <= !serial ? '0 : (sbit ? SYM_ONE_HIGH : SYM_ZERO_HIGH);
        low_time    <= !serial ? '0 : (sbit ? SYM_ONE_LOW : SYM_ZERO_LOW);
        last_symbol <= last_of_job;
      end
      if (job.start) begin
        busy   <= 1'b1;
        serial <= job.serial;
        pin    <= job.pin;
        shreg  <= job.grb;
        idx    <= '0;
      end else if (advance) begin
        shreg <= shreg << 1;
        idx   <= idx + CNT_W'(1);
        if (last_of_job) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/heartbeat_led_serial_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_led_serial_color
// Heartbeat LED blinker with a plain pin or serial RGB LED output.
// ----------------------------------------------------------------------------
// Each word on in_ch is a tick, an activity mark or an error set/clear;
// other codes are ignored. A tick that finds the toggle interval elapsed
// flips the LED and starts a job. In pin mode a job yields one result word;
// in serial mode it yields 24 pulse symbols, green, red, blue, msb first,
// one per cycle from the serializer while out_ch is not stalled. in_ch is
// ready whenever the serializer has no job or is handing out the last word
// of its job, so in serial mode a toggling tick holds off the next input
// word until its last symbol is loaded into the result register. Time
// values are TIME_WIDTH bits and wrap.
// ----------------------------------------------------------------------------
module heartbeat_led_serial_color #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  hbled_in_if.sink                          in_ch,
  hbled_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [hbled_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbled_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hbled_pkg::*;

  job_t job;
  logic job_free;
  logic in_fire;

  assign in_ch.ready = job_free;
  assign in_fire     = in_ch.valid && job_free;

  hbled_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_func   (in_ch.func),
    .in_now    (in_ch.now_time),
    .in_err    (in_ch.error_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job)
  );

  hbled_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_free    (job_free),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .result_kind (out_ch.result_kind),
    .pin_level   (out_ch.pin_level),
    .symbol_bit  (out_ch.symbol_bit),
    .high_time   (out_ch.high_time),
    .low_time    (out_ch.low_time),
    .last_symbol (out_ch.last_symbol)
  );

endmodule

// ===== test/heartbeat_led_serial_color_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_led_serial_color_test
// Self-checking bench for the heartbeat LED blinker. Directed tests walk the
// reset settings, pin polarity, the interval extremes, time wrap and the
// serial color choice (fault, busy, idle, black). Random phases follow, each
// with fresh register settings, mostly advancing ticks mixed with marks,
// error changes, unused codes and stray timestamps. A shadow blinker turns
// every accepted input word into the result words it should cause, and a
// monitor checks the result channel against them in order, field by field.
// Both channels idle at random; the result side also stalls for long runs.
// ----------------------------------------------------------------------------
module heartbeat_led_serial_color_test;
  import hbled_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_REPORTS   = 10;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 43;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic               kind;
    logic               pin;
    logic               data_bit;
    logic [PULSE_W-1:0] high_len;
    logic [PULSE_W-1:0] low_len;
    logic               last;
  } led_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hbled_in_if  in_ch ();
  hbled_out_if out_ch ();

  heartbeat_led_serial_color u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers and blinker state
  logic               reg_serial;
  logic               reg_polarity;
  logic [NOW_W-1:0]   reg_interval;
  logic [NOW_W-1:0]   reg_window;
  logic [COLOR_W-1:0] reg_idle;
  logic [COLOR_W-1:0] reg_busy;
  logic [COLOR_W-1:0] reg_fault;
  logic               led_lit;
  logic               fault_flag;
  logic [NOW_W-1:0]   toggle_time;
  logic [NOW_W-1:0]   mark_time;

  led_word_t led_word_q[$];

  int mismatch_count = 0;
  int words_checked  = 0;
  int items_sent     = 0;
  int toggle_count   = 0;
  int cycle_count    = 0;
  bit sender_burst   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               led_word_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SERIAL_MODE:  reg_serial   = data[0];
      CFG_PIN_POLARITY: reg_polarity = data[0];
      CFG_INTERVAL:     reg_interval = data[NOW_W-1:0];
      CFG_WINDOW:       reg_window   = data[NOW_W-1:0];
      CFG_IDLE_COLOR:   reg_idle     = data[COLOR_W-1:0];
      CFG_BUSY_COLOR:   reg_busy     = data[COLOR_W-1:0];
      CFG_FAULT_COLOR:  reg_fault    = data[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic advance_blinker(input logic [FUNC_W-1:0] f, input logic [NOW_W-1:0] now,
                                 input logic ev);
    logic [NOW_W-1:0]   elapsed;
    logic [NOW_W-1:0]   since_mark;
    logic               busy;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] grb;
    led_word_t          w;
    int                 k;
    case (f)
      FUNC_MARK:  mark_time  = now;
      FUNC_ERROR: fault_flag = ev;
      FUNC_TICK: begin
        elapsed = now - toggle_time;
        if (elapsed >= reg_interval) begin
          since_mark  = now - mark_time;
          busy        = (reg_window != '0) && (since_mark <= reg_window);
          led_lit     = ~led_lit;
          toggle_time = now;
          toggle_count++;
          if (!reg_serial) begin
            w = '{KIND_PIN, reg_polarity ? led_lit : ~led_lit, 1'b0, '0, '0, 1'b1};
            led_word_q.push_back(w);
          end else begin
            if (!led_lit) color = '0;
            else if (fault_flag) color = reg_fault;
            else if (busy) color = reg_busy;
            else color = reg_idle;
            grb = {color[15:8], color[23:16], color[7:0]};
            for (k = 0; k < SYMBOL_COUNT; k++) begin
              w.kind     = KIND_SYMBOL;
              w.pin      = 1'b0;
              w.data_bit = grb[SYMBOL_COUNT-1-k];
              w.high_len = w.data_bit ? SYM_ONE_HIGH : SYM_ZERO_HIGH;
              w.low_len  = w.data_bit ? SYM_ONE_LOW : SYM_ZERO_LOW;
              w.last     = (k == SYMBOL_COUNT - 1);
              led_word_q.push_back(w);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    led_word_t got;
    led_word_t want;
    got = {out_ch.result_kind, out_ch.pin_level, out_ch.symbol_bit, out_ch.high_time,
           out_ch.low_time, out_ch.last_symbol};
    if (led_word_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: result word %p with nothing pending", $realtime, got);
    end else begin
      want = led_word_q.pop_front();
      words_checked++;
      if (got.kind !== want.kind || got.pin !== want.pin || got.data_bit !== want.data_bit ||
          got.high_len !== want.high_len || got.low_len !== want.low_len ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: word %0d mismatch, expected %p, got %p", $realtime, words_checked,
                   want, got);
      end
    end
  endtask

  // config, input and result handshakes are all seen in one place
  always @(posedge clk) begin
    if (rst) begin
      reg_serial   = 1'b0;
      reg_polarity = 1'b1;
      reg_interval = RST_INTERVAL;
      reg_window   = '0;
      reg_idle     = '0;
      reg_busy     = '0;
      reg_fault    = '0;
      led_lit      = 1'b0;
      fault_flag   = 1'b0;
      toggle_time  = '0;
      mark_time    = '0;
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready)
        advance_blinker(in_ch.func, in_ch.now_time, in_ch.error_value);
      if (out_ch.valid && out_ch.ready) check_word();
    end
  end

  initial begin : result_sink
    int n_on;
    int n_off;
    int r;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) n_on = $urandom_range(80, 200);
      else n_on = $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (n_on) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 25) n_off = 0;
      else if (r < 90) n_off = $urandom_range(1, 3);
      else n_off = $urandom_range(10, 30);
      if (n_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n_off) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [NOW_W-1:0] now,
                           input logic ev);
    int r;
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.now_time    <= now;
    in_ch.error_value <= ev;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (led_word_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NOW_W-1:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // reset settings: pin mode, active high, interval 100
  task automatic test_reset_values();
    send_word(FUNC_TICK, 32'd50, 1'b0);
    send_word(FUNC_TICK, 32'd100, 1'b0);
    send_word(FUNC_MARK, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_ERROR, 32'h0000_0000, 1'b1);
    send_word(FUNC_UNUSED, 32'hA5A5_5A5A, 1'b1);
    send_word(FUNC_TICK, 32'd199, 1'b0);
    send_word(FUNC_TICK, 32'd200, 1'b0);
  endtask

  task automatic test_pin_polarity();
    wait_idle();
    write_reg(CFG_PIN_POLARITY, 32'hFFFF_FFFE);
    write_reg(CFG_INTERVAL, 32'h0000_0000);
    end_writes();
    send_word(FUNC_TICK, 32'd200, 1'b0);
    send_word(FUNC_TICK, 32'd200, 1'b0);
    wait_idle();
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    end_writes();
    send_word(FUNC_TICK, 32'd0, 1'b0);
    send_word(FUNC_TICK, 32'd199, 1'b0);
  endtask

  task automatic test_time_wrap();
    wait_idle();
    write_reg(CFG_PIN_POLARITY, 32'h0000_0001);
    write_reg(CFG_INTERVAL, 32'h0000_0020);
    end_writes();
    send_word(FUNC_TICK, 32'hFFFF_FFF0, 1'b0);
    send_word(FUNC_TICK, 32'h0000_000F, 1'b0);
    send_word(FUNC_TICK, 32'h0000_0010, 1'b0);
  endtask

  task automatic test_serial_colors();
    wait_idle();
    write_reg(CFG_SERIAL_MODE, 32'h0000_0003);
    write_reg(CFG_WINDOW, 32'd10);
    write_reg(CFG_IDLE_COLOR, 32'h0012_3456);
    write_reg(CFG_BUSY_COLOR, 32'hFFA5_C30F);
    write_reg(CFG_FAULT_COLOR, 32'h00FF_FFFF);
    write_reg(CFG_INTERVAL, 32'd5);
    end_writes();
    send_word(FUNC_ERROR, 32'h0, 1'b0);
    send_word(FUNC_TICK, 32'h100, 1'b0);
    send_word(FUNC_TICK, 32'h105, 1'b0);
    send_word(FUNC_MARK, 32'h108, 1'b0);
    send_word(FUNC_TICK, 32'h10A, 1'b0);
    send_word(FUNC_TICK, 32'h10F, 1'b0);
    send_word(FUNC_TICK, 32'h114, 1'b0);
    send_word(FUNC_ERROR, 32'h0, 1'b1);
    send_word(FUNC_TICK, 32'h119, 1'b0);
    send_word(FUNC_TICK, 32'h11E, 1'b0);
    send_word(FUNC_ERROR, 32'h0, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [NOW_W-1:0]      interval;
    logic [NOW_W-1:0]      cur_time;
    logic [NOW_W-1:0]      step;
    logic [CFG_DATA_W-1:0] data;
    int                    phase;
    int                    i;
    int                    r;
    int                    s;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      sender_burst = (phase == 6);
      data    = $urandom;
      data[0] = (phase % 3 != 0);
      write_reg(CFG_SERIAL_MODE, data);
      write_reg(CFG_PIN_POLARITY, $urandom);
      interval = pick_span();
      write_reg(CFG_INTERVAL, interval);
      write_reg(CFG_WINDOW, pick_span());
      write_reg(CFG_IDLE_COLOR, pick_color());
      write_reg(CFG_BUSY_COLOR, pick_color());
      write_reg(CFG_FAULT_COLOR, pick_color());
      end_writes();
      cur_time = $urandom;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // hold off until the block has drained
        if (phase == 4 && i == PHASE_ITEMS / 2) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 68) begin
          s = $urandom_range(0, 99);
          if (s < 50) step = interval + $urandom_range(0, 3);
          else if (s < 65) step = interval - 1;
          else if (s < 85) step = $urandom_range(0, 48);
          else step = $urandom;
          cur_time = cur_time + step;
          send_word(FUNC_TICK, cur_time, 1'($urandom_range(0, 1)));
        end else if (r < 80) begin
          send_word(FUNC_MARK, cur_time - $urandom_range(0, 20), 1'($urandom_range(0, 1)));
        end else if (r < 90) begin
          send_word(FUNC_ERROR, $urandom, 1'($urandom_range(0, 1)));
        end else if (r < 95) begin
          send_word(FUNC_UNUSED, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          send_word(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)));
        end
      end
    end
    sender_burst = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_TICK;
    in_ch.now_time    = '0;
    in_ch.error_value = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_pin_polarity();
    test_time_wrap();
    test_serial_colors();
    test_random_traffic();

    wait_idle();
    $display("%0d input words, %0d result words checked, %0d LED toggles, %0d mismatches",
             items_sent, words_checked, toggle_count, mismatch_count);
    $display("pin and serial output, both polarities, interval and window extremes, wrap, %0d %s",
             RAND_PHASES, "random register settings");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== heartbeat_led_serial_color.f =====
rtl/hbled_pkg.sv
rtl/hbled_if.sv
rtl/hbled_core.sv
rtl/hbled_ser.sv
rtl/heartbeat_led_serial_color.sv
test/heartbeat_led_serial_color_test.sv
